@@ hw/rtl/cfc_pkg.sv @@
// shared types and constants of the column fir filter
`timescale 1ns / 1ps

package cfc_pkg;

  // kind of an input transaction, carried on tuser
  localparam logic CMD_COEF   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // configuration register indexes
  localparam int CFG_AW = 2;
  localparam int CFG_DW = 5;
  localparam logic [CFG_AW-1:0] CFG_BEGIN = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_END   = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_DECIM = 2'd2;
  localparam logic [CFG_AW-1:0] CFG_PAD   = 2'd3;

  localparam int OFF_BITS  = 5;  // tap offset registers
  localparam int OFF_W     = 8;  // signed working width for tap offsets
  localparam int D_W       = 5;  // flush row offset
  localparam int STEP_W    = 4;  // decimation step
  localparam int IDX_BITS  = 5;  // coefficient slot field

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_DIV   = 7'b0000010,
    ST_ROW   = 7'b0000100,
    ST_TAP   = 7'b0001000,
    ST_DRAIN = 7'b0010000,
    ST_EMIT  = 7'b0100000,
    ST_NEXT  = 7'b1000000
  } state_t;

  typedef struct packed {
    logic shift;  // push a new sample into the window
    logic load;   // copy the window into the scan line
    logic adv;    // move the scan line one place towards the head
  } cell_ctrl_t;

endpackage

@@ hw/rtl/cfc_cell.sv @@
// one cell of the sample window: a window stage and a scan stage
`timescale 1ns / 1ps

module cfc_cell #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                    clk,
  input  cfc_pkg::cell_ctrl_t     ctrl,
  input  logic [SAMPLE_BITS-1:0]  win_in,
  input  logic [SAMPLE_BITS-1:0]  scan_in,
  output logic [SAMPLE_BITS-1:0]  win_out,
  output logic [SAMPLE_BITS-1:0]  scan_out
);

  logic [SAMPLE_BITS-1:0] win;
  logic [SAMPLE_BITS-1:0] scan;

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      win <= win_in;
    end
    if (ctrl.load) begin
      scan <= win;
    end else if (ctrl.adv) begin
      scan <= scan_in;
    end
  end

  assign win_out  = win;
  assign scan_out = scan;

endmodule

@@ hw/rtl/cfc_div.sv @@
// restoring divider: row index by decimation step, one quotient bit a cycle
`timescale 1ns / 1ps

module cfc_div #(
  parameter int ROW_BITS = 12
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [ROW_BITS-1:0]         dividend,
  input  logic [cfc_pkg::STEP_W-1:0]  divisor,
  output logic                        done,
  output logic [ROW_BITS-1:0]         quot,
  output logic [cfc_pkg::STEP_W-1:0]  rem
);

  localparam int CW = $clog2(ROW_BITS + 1);

  logic                        busy;
  logic [CW-1:0]               cnt;
  logic [cfc_pkg::STEP_W:0]    trial;
  logic                        fits;

  assign trial = {rem, quot[ROW_BITS-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt  <= CW'(ROW_BITS);
      quot <= dividend;
      rem  <= '0;
    end else if (busy) begin
      cnt  <= cnt - CW'(1);
      quot <= {quot[ROW_BITS-2:0], fits};
      rem  <= fits ? cfc_pkg::STEP_W'(trial - {1'b0, divisor})
                   : trial[cfc_pkg::STEP_W-1:0];
    end
  end

endmodule

@@ hw/rtl/cfc_mac.sv @@
// coefficient store and multiply-accumulate with rounding and clamping
`timescale 1ns / 1ps

module cfc_mac #(
  parameter int MAX_TAPS    = 31,
  parameter int SAMPLE_BITS = 16,
  parameter int COEF_BITS   = 18
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          coef_we,
  input  logic [$clog2(MAX_TAPS)-1:0]   coef_waddr,
  input  logic signed [COEF_BITS-1:0]   coef_wdata,
  input  logic                          tap_valid,
  input  logic [$clog2(MAX_TAPS)-1:0]   tap_addr,
  input  logic [SAMPLE_BITS-1:0]        tap_sample,
  input  logic                          acc_clr,
  output logic                          busy,
  output logic [SAMPLE_BITS-1:0]        res_val,
  output logic                          res_sat
);

  localparam int FRAC   = COEF_BITS - 2;
  localparam int PROD_W = SAMPLE_BITS + COEF_BITS + 1;
  localparam int ACC_W  = PROD_W + $clog2(MAX_TAPS) + 1;
  localparam logic [ACC_W:0] RND = (ACC_W + 1)'(1) << (FRAC - 1);

  logic signed [COEF_BITS-1:0] coef_mem [MAX_TAPS];
  logic signed [COEF_BITS-1:0] coef_q;
  logic [SAMPLE_BITS-1:0]      sample_q;
  logic signed [PROD_W-1:0]    prod;
  logic signed [ACC_W-1:0]     acc;
  logic                        va;
  logic                        vb;
  logic [ACC_W:0]              rnd;
  logic                        over;

  always_ff @(posedge clk) begin
    if (coef_we) begin
      coef_mem[coef_waddr] <= coef_wdata;
    end
    coef_q <= coef_mem[tap_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
    end else begin
      va <= tap_valid;
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    sample_q <= tap_sample;
    prod     <= PROD_W'(coef_q * $signed({1'b0, sample_q}));
    if (acc_clr) begin
      acc <= '0;
    end else if (vb) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  assign busy = va | vb;

  // round half up, then clamp to the sample range
  assign rnd  = (ACC_W + 1)'(acc) + RND;
  assign over = |rnd[ACC_W-1:FRAC+SAMPLE_BITS];

  always_comb begin
    if (rnd[ACC_W]) begin
      res_val = '0;
      res_sat = 1'b1;
    end else if (over) begin
      res_val = '1;
      res_sat = 1'b1;
    end else begin
      res_val = rnd[FRAC+SAMPLE_BITS-1:FRAC];
      res_sat = 1'b0;
    end
  end

endmodule

@@ hw/rtl/column_fir_with_edge_padding_top.sv @@
// top level: window cell chain, row sequencer, configuration and stream ports
`timescale 1ns / 1ps

// Column FIR filter with zero or edge-replicate padding. Coefficient transactions
// (tuser 0) are taken in the idle state. A sample transaction (tuser 1) enters the
// window, the restoring divider if the first candidate row is not negative, then the
// row and next states per candidate row, and for an emitted row the tap, drain and
// emit states (emit only, if the support is empty), the result waiting for m_tready.
// Taps go one a cycle through the single multiply-accumulate unit, fed by a scan line
// along the chain of window cells. A non-final sample has one candidate row; a tlast
// sample has 1 - b, b being filter_begin clamped to -HALF..0. Configuration writes
// must be made only while no transaction is in flight; the block does not enforce it.
module column_fir_with_edge_padding_top #(
  parameter int MAX_TAPS    = 31,
  parameter int SAMPLE_BITS = 16,
  parameter int COEF_BITS   = 18,
  parameter int MAX_ROWS    = 4096,
  localparam int ROW_BITS   = $clog2(MAX_ROWS),
  localparam int IN_W  = ((cfc_pkg::IDX_BITS + COEF_BITS + SAMPLE_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((SAMPLE_BITS + ROW_BITS + 7) / 8) * 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [IN_W-1:0]             s_tdata,   // coef_index, coef_value, pixel
  input  logic                        s_tuser,   // command
  input  logic                        s_tlast,   // last_in_column
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [OUT_W-1:0]            m_tdata,   // filtered, out_row
  output logic                        m_tuser,   // saturated
  output logic                        m_tlast,   // last_of_run
  input  logic                        cfg_wr_en,
  input  logic [cfc_pkg::CFG_AW-1:0]  cfg_addr,
  input  logic [cfc_pkg::CFG_DW-1:0]  cfg_wdata
);

  localparam int TAP_AW = $clog2(MAX_TAPS);
  localparam int CNT_W  = $clog2(MAX_TAPS + 1);
  localparam int Y_W    = ROW_BITS + 2;
  localparam int HALF   = (MAX_TAPS - 1) / 2;
  localparam int VAL_LO = cfc_pkg::IDX_BITS;
  localparam int PIX_LO = cfc_pkg::IDX_BITS + COEF_BITS;
  localparam logic signed [cfc_pkg::OFF_W-1:0] NEG_HALF = cfc_pkg::OFF_W'(-HALF);
  localparam logic signed [cfc_pkg::OFF_W-1:0] SPAN     = cfc_pkg::OFF_W'(MAX_TAPS - 1);

  // configuration registers
  logic signed [cfc_pkg::OFF_BITS-1:0] cfg_begin;
  logic signed [cfc_pkg::OFF_BITS-1:0] cfg_end;
  logic [cfc_pkg::STEP_W-1:0]          cfg_decim;
  logic                                cfg_pad;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_begin <= '0;
      cfg_end   <= '0;
      cfg_decim <= cfc_pkg::STEP_W'(1);
      cfg_pad   <= 1'b1;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        cfc_pkg::CFG_BEGIN: cfg_begin <= cfg_wdata[cfc_pkg::OFF_BITS-1:0];
        cfc_pkg::CFG_END:   cfg_end   <= cfg_wdata[cfc_pkg::OFF_BITS-1:0];
        cfc_pkg::CFG_DECIM: cfg_decim <= cfg_wdata[cfc_pkg::STEP_W-1:0];
        cfc_pkg::CFG_PAD:   cfg_pad   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  cfc_pkg::state_t state;

  logic                         s_acc;
  logic                         smp_acc;
  logic [cfc_pkg::IDX_BITS-1:0] in_idx;
  logic [SAMPLE_BITS-1:0]       in_pix;

  assign s_tready = state == cfc_pkg::ST_IDLE;
  assign s_acc    = s_tvalid && s_tready;
  assign smp_acc  = s_acc && s_tuser == cfc_pkg::CMD_SAMPLE;
  assign in_idx   = s_tdata[cfc_pkg::IDX_BITS-1:0];
  assign in_pix   = s_tdata[PIX_LO +: SAMPLE_BITS];

  // per-transaction settings derived from the registers
  logic signed [cfc_pkg::OFF_W-1:0] b_raw, b_eff, e_raw, e_lim, e_eff;
  logic [cfc_pkg::STEP_W-1:0]       step_eff;
  logic signed [Y_W-1:0]            y0;

  always_comb begin
    b_raw = cfc_pkg::OFF_W'(cfg_begin);
    if (b_raw > 0) begin
      b_eff = '0;
    end else if (b_raw < NEG_HALF) begin
      b_eff = NEG_HALF;
    end else begin
      b_eff = b_raw;
    end
    e_raw = cfc_pkg::OFF_W'(cfg_end);
    e_lim = b_eff + SPAN;
    e_eff = (e_raw > e_lim) ? e_lim : e_raw;
    step_eff = (cfg_decim == '0) ? cfc_pkg::STEP_W'(1) : cfg_decim;
  end

  // sequencer registers
  logic [ROW_BITS-1:0]        row_counter;
  logic [CNT_W-1:0]           fill;
  logic [SAMPLE_BITS-1:0]     top_sample;
  logic signed [Y_W-1:0]      ycur;
  logic [cfc_pkg::D_W-1:0]    d, dmax, lead;
  logic [cfc_pkg::STEP_W-1:0] step_q, rem;
  logic [ROW_BITS-1:0]        q_row;
  logic [CNT_W-1:0]           n_q, t, idx, fill_q;
  logic                       empty_q, pad_q;

  assign y0 = Y_W'($signed({1'b0, row_counter})) + Y_W'(b_eff);

  // divider
  logic                        div_start, div_done;
  logic [ROW_BITS-1:0]         div_quot;
  logic [cfc_pkg::STEP_W-1:0]  div_rem;

  assign div_start = smp_acc && !y0[Y_W-1];

  cfc_div #(.ROW_BITS(ROW_BITS)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (y0[ROW_BITS-1:0]),
    .divisor  (step_eff),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // window cell chain
  cfc_pkg::cell_ctrl_t    ctrl;
  logic [SAMPLE_BITS-1:0] win_link  [MAX_TAPS+1];
  logic [SAMPLE_BITS-1:0] scan_link [MAX_TAPS+1];
  logic                   emit_row;

  assign emit_row   = !ycur[Y_W-1] && rem == '0;
  assign ctrl.shift = smp_acc;
  assign ctrl.load  = state == cfc_pkg::ST_ROW && emit_row && !empty_q;
  assign ctrl.adv   = state == cfc_pkg::ST_TAP && lead == '0;

  assign win_link[0]         = in_pix;
  assign scan_link[MAX_TAPS] = '0;

  for (genvar g = 0; g < MAX_TAPS; g++) begin : g_cell
    cfc_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .win_in   (win_link[g]),
      .scan_in  (scan_link[g+1]),
      .win_out  (win_link[g+1]),
      .scan_out (scan_link[g])
    );
  end

  // tap sample: leading rows past the bottom, window, or rows above the top
  logic [SAMPLE_BITS-1:0] tap_sample;

  always_comb begin
    if (lead != '0) begin
      tap_sample = pad_q ? win_link[1] : '0;
    end else if (idx < fill_q) begin
      tap_sample = scan_link[0];
    end else begin
      tap_sample = pad_q ? top_sample : '0;
    end
  end

  logic                   mac_busy, res_sat;
  logic [SAMPLE_BITS-1:0] res_val;

  cfc_mac #(
    .MAX_TAPS    (MAX_TAPS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .COEF_BITS   (COEF_BITS)
  ) u_mac (
    .clk        (clk),
    .rst        (rst),
    .coef_we    (s_acc && s_tuser == cfc_pkg::CMD_COEF && 32'(in_idx) < MAX_TAPS),
    .coef_waddr (TAP_AW'(in_idx)),
    .coef_wdata (s_tdata[VAL_LO +: COEF_BITS]),
    .tap_valid  (state == cfc_pkg::ST_TAP),
    .tap_addr   (TAP_AW'(t)),
    .tap_sample (tap_sample),
    .acc_clr    (ctrl.load),
    .busy       (mac_busy),
    .res_val    (res_val),
    .res_sat    (res_sat)
  );

  // output register
  logic                   can_load;
  logic [SAMPLE_BITS-1:0] out_val;
  logic [ROW_BITS-1:0]    out_row;
  logic                   out_sat, out_last;

  assign can_load = !m_tvalid || m_tready;
  assign m_tdata  = OUT_W'({out_row, out_val});
  assign m_tuser  = out_sat;
  assign m_tlast  = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == cfc_pkg::ST_EMIT && can_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == cfc_pkg::ST_EMIT && can_load) begin
      out_val  <= empty_q ? '0 : res_val;
      out_sat  <= empty_q ? 1'b0 : res_sat;
      out_row  <= q_row;
      // no later row in this run is a multiple of the step
      out_last <= (dmax - d) < {1'b0, step_q};
    end
  end

  // column state
  always_ff @(posedge clk) begin
    if (rst) begin
      row_counter <= '0;
      fill        <= '0;
      top_sample  <= '0;
    end else if (smp_acc) begin
      if (fill == '0) begin
        top_sample <= in_pix;
      end
      if (s_tlast) begin
        row_counter <= '0;
        fill        <= '0;
      end else begin
        row_counter <= row_counter + ROW_BITS'(1);
        fill        <= (fill == CNT_W'(MAX_TAPS)) ? fill : fill + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cfc_pkg::ST_IDLE;
    end else begin
      unique case (state)
        cfc_pkg::ST_IDLE: begin
          if (smp_acc) begin
            state <= y0[Y_W-1] ? cfc_pkg::ST_ROW : cfc_pkg::ST_DIV;
          end
        end
        cfc_pkg::ST_DIV: begin
          if (div_done) begin
            state <= cfc_pkg::ST_ROW;
          end
        end
        cfc_pkg::ST_ROW: begin
          if (!emit_row) begin
            state <= cfc_pkg::ST_NEXT;
          end else if (empty_q) begin
            state <= cfc_pkg::ST_EMIT;
          end else begin
            state <= cfc_pkg::ST_TAP;
          end
        end
        cfc_pkg::ST_TAP: begin
          if (t == n_q - CNT_W'(1)) begin
            state <= cfc_pkg::ST_DRAIN;
          end
        end
        cfc_pkg::ST_DRAIN: begin
          if (!mac_busy) begin
            state <= cfc_pkg::ST_EMIT;
          end
        end
        cfc_pkg::ST_EMIT: begin
          if (can_load) begin
            state <= cfc_pkg::ST_NEXT;
          end
        end
        cfc_pkg::ST_NEXT: begin
          state <= (d == dmax) ? cfc_pkg::ST_IDLE : cfc_pkg::ST_ROW;
        end
        default: state <= cfc_pkg::ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      cfc_pkg::ST_IDLE: begin
        if (smp_acc) begin
          ycur    <= y0;
          d       <= '0;
          dmax    <= s_tlast ? cfc_pkg::D_W'(-b_eff) : '0;
          step_q  <= step_eff;
          empty_q <= e_eff < b_eff;
          n_q     <= CNT_W'(e_eff - b_eff + cfc_pkg::OFF_W'(1));
          pad_q   <= cfg_pad;
          fill_q  <= (fill == CNT_W'(MAX_TAPS)) ? fill : fill + CNT_W'(1);
          q_row   <= '0;
          rem     <= '0;
        end
      end
      cfc_pkg::ST_DIV: begin
        if (div_done) begin
          q_row <= div_quot;
          rem   <= div_rem;
        end
      end
      cfc_pkg::ST_ROW: begin
        t    <= '0;
        idx  <= '0;
        lead <= d;
      end
      cfc_pkg::ST_TAP: begin
        t <= t + CNT_W'(1);
        if (lead != '0) begin
          lead <= lead - cfc_pkg::D_W'(1);
        end else begin
          idx <= idx + CNT_W'(1);
        end
      end
      cfc_pkg::ST_NEXT: begin
        d    <= d + cfc_pkg::D_W'(1);
        ycur <= ycur + Y_W'(1);
        if (!ycur[Y_W-1]) begin
          if (rem == step_q - cfc_pkg::STEP_W'(1)) begin
            rem   <= '0;
            q_row <= q_row + ROW_BITS'(1);
          end else begin
            rem <= rem + cfc_pkg::STEP_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_emit_loads: assert property (@(posedge clk) disable iff (rst)
    (state == cfc_pkg::ST_EMIT && can_load) |=> m_tvalid)
    else $error("result not presented after emit");

  a_lead_no_scan: assert property (@(posedge clk) disable iff (rst)
    (state == cfc_pkg::ST_TAP && lead != '0) |-> (idx == '0))
    else $error("scan line moved during bottom padding");

  a_div_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == cfc_pkg::ST_DIV))
    else $error("divider finished outside its state");

  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    (state == cfc_pkg::ST_ROW) |-> (rem < step_q))
    else $error("row residue out of range");
`endif

endmodule

@@ dv/testbench.sv @@
// self-checking testbench for the column fir filter with edge padding
`timescale 1ns / 1ps

module testbench;

  localparam int TAPS     = 31;
  localparam int HALF     = (TAPS - 1) / 2;
  localparam int FRAC     = 16;
  localparam int ROWS     = 4096;
  localparam int IN_W     = 40;
  localparam int OUT_W    = 32;
  localparam int SETTLE   = 800;
  localparam int HOLD_LEN = 400;
  localparam longint CYCLE_LIMIT = 2_000_000;

  typedef struct packed {
    logic [15:0] filtered;
    logic [11:0] out_row;
    logic        saturated;
    logic        last_of_run;
  } fir_row_t;

  class column_scoreboard;
    int         cfg_begin;
    int         cfg_end;
    int         cfg_step;
    bit         cfg_pad;
    bit [15:0]  window[TAPS];
    bit [15:0]  top_px;
    int         row_cnt;
    int         fill;
    longint     coefs[TAPS];
    fir_row_t   rows_due[$];

    function new();
      cfg_begin = 0;
      cfg_end   = 0;
      cfg_step  = 1;
      cfg_pad   = 1;
      top_px    = 0;
      row_cnt   = 0;
      fill      = 0;
      foreach (window[i]) window[i] = 0;
      foreach (coefs[i]) coefs[i] = 0;
    endfunction

    function void set_reg(logic [cfc_pkg::CFG_AW-1:0] addr,
                          logic [cfc_pkg::CFG_DW-1:0] data);
      case (addr)
        cfc_pkg::CFG_BEGIN: cfg_begin = $signed(data);
        cfc_pkg::CFG_END:   cfg_end   = $signed(data);
        cfc_pkg::CFG_DECIM: cfg_step  = data[3:0];
        cfc_pkg::CFG_PAD:   cfg_pad   = data[0];
        default: ;
      endcase
    endfunction

    function int pending();
      return rows_due.size();
    endfunction

    // one filtered row, d rows past the newest sample's normal row
    function fir_row_t filter_row(int b, int e, int d);
      fir_row_t res;
      longint   acc;
      longint   px;
      longint   t;
      int       i;
      acc = 0;
      res = '0;
      for (int k = b; k <= e; k++) begin
        i = k - b - d;
        if (i < 0) px = cfg_pad ? window[0] : 0;
        else if (i >= fill) px = cfg_pad ? top_px : 0;
        else px = window[i];
        acc += coefs[k - b] * px;
      end
      t = acc + (longint'(1) << (FRAC - 1));
      if (t < 0) begin
        res.saturated = 1;
      end else if ((t >>> FRAC) > 65535) begin
        res.filtered  = 16'hffff;
        res.saturated = 1;
      end else begin
        res.filtered = t >>> FRAC;
      end
      return res;
    endfunction

    function void note_input(bit cmd, bit [4:0] idx, bit [17:0] cv, bit [15:0] px, bit lst);
      int       b;
      int       e;
      int       step;
      int       dmax;
      int       y;
      int       n;
      fir_row_t res;
      if (cmd == cfc_pkg::CMD_COEF) begin
        if (idx < TAPS) coefs[idx] = $signed(cv);
        return;
      end
      if (fill == 0) top_px = px;
      for (int i = TAPS - 1; i > 0; i--) window[i] = window[i-1];
      window[0] = px;
      if (fill < TAPS) fill++;
      b = cfg_begin > 0 ? 0 : cfg_begin;
      if (b < -HALF) b = -HALF;
      e = cfg_end;
      if (e > b + TAPS - 1) e = b + TAPS - 1;
      step = cfg_step == 0 ? 1 : cfg_step;
      dmax = lst ? -b : 0;
      n = 0;
      for (int d = 0; d <= dmax; d++) begin
        y = row_cnt + b + d;
        if (y < 0 || (y % step) != 0) continue;
        res = (e >= b) ? filter_row(b, e, d) : '0;
        res.out_row = (y / step) % ROWS;
        res.last_of_run = 0;
        rows_due.push_back(res);
        n++;
      end
      if (n > 0) rows_due[rows_due.size()-1].last_of_run = 1;
      if (lst) begin
        row_cnt = 0;
        fill = 0;
      end else begin
        row_cnt = (row_cnt + 1) % ROWS;
      end
    endfunction

    // empty string when the row matches
    function string check_row(fir_row_t got);
      fir_row_t want;
      if (rows_due.size() == 0)
        return $sformatf("unexpected row %0d value %0d", got.out_row, got.filtered);
      want = rows_due.pop_front();
      if (got.filtered !== want.filtered || got.out_row !== want.out_row ||
          got.saturated !== want.saturated || got.last_of_run !== want.last_of_run)
        return $sformatf("row %0d: got val %0d sat %0b last %0b, want row %0d val %0d sat %0b last %0b",
                         got.out_row, got.filtered, got.saturated, got.last_of_run,
                         want.out_row, want.filtered, want.saturated, want.last_of_run);
      return "";
    endfunction
  endclass

  logic                       clk;
  logic                       rst;
  logic                       s_tvalid;
  logic                       s_tready;
  logic [IN_W-1:0]            s_tdata;   // coef_index, coef_value, pixel
  logic                       s_tuser;   // command
  logic                       s_tlast;   // last_in_column
  logic                       m_tvalid;
  logic                       m_tready;
  logic [OUT_W-1:0]           m_tdata;   // filtered, out_row
  logic                       m_tuser;   // saturated
  logic                       m_tlast;   // last_of_run
  logic                       cfg_wr_en;
  logic [cfc_pkg::CFG_AW-1:0] cfg_addr;
  logic [cfc_pkg::CFG_DW-1:0] cfg_wdata;

  column_scoreboard sb;
  int     errors;
  int     items_sent;
  int     rows_seen;
  int     columns_run;
  longint cycles;
  bit     send_gaps;
  bit     recv_gaps;
  bit     hold_request;

  column_fir_with_edge_padding_top uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast),
    .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic report(string msg);
    errors++;
    $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  task automatic send(bit cmd, bit [4:0] idx, bit [17:0] cv, bit [15:0] px, bit lst);
    int gap;
    gap = send_gaps ? $urandom_range(0, 6) : 0;
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = cmd;
    s_tlast  = lst;
    s_tdata  = {px, cv, idx};
    do @(posedge clk); while (!s_tready);
    sb.note_input(cmd, idx, cv, px, lst);
    items_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    // coefficient transactions leave nothing to wait for, so let the block settle
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic configure(logic [4:0] fb, logic [4:0] fe, logic [3:0] step, bit pad);
    drain();
    for (int a = 0; a < 4; a++) begin
      cfg_wr_en = 1'b1;
      cfg_addr  = a;
      case (a)
        cfc_pkg::CFG_BEGIN: cfg_wdata = fb;
        cfc_pkg::CFG_END:   cfg_wdata = fe;
        cfc_pkg::CFG_DECIM: cfg_wdata = {1'b0, step};
        default:            cfg_wdata = {4'b0, pad};
      endcase
      sb.set_reg(cfg_addr, cfg_wdata);
      @(negedge clk);
    end
    cfg_wr_en = 1'b0;
  endtask

  // gentle taps keep most rows in range, wide ones saturate both ways
  task automatic load_coefs(int scale);
    bit [17:0] cv;
    for (int i = 0; i < TAPS; i++) begin
      if (scale == 0) cv = $urandom();
      else cv = $urandom_range(0, 2 * scale) - scale + 4000;
      send(cfc_pkg::CMD_COEF, i, cv, $urandom(), $urandom_range(0, 1));
    end
  endtask

  task automatic run_column(int len);
    bit [15:0] px;
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 7))
        0: px = 16'h0000;
        1: px = 16'hffff;
        default: px = $urandom();
      endcase
      // stray coefficient write mid column, slot 31 is ignored
      if ($urandom_range(0, 19) == 0)
        send(cfc_pkg::CMD_COEF, $urandom_range(0, 31), $urandom(), $urandom(),
             $urandom_range(0, 1));
      send(cfc_pkg::CMD_SAMPLE, $urandom(), $urandom(), px, i == len - 1);
    end
    columns_run++;
  endtask

  // receiver
  initial begin
    fir_row_t got;
    string    msg;
    int       gap;
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        m_tready = 1'b0;
        repeat (HOLD_LEN) @(negedge clk);
        hold_request = 0;
      end
      gap = recv_gaps ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        m_tready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready = 1'b1;
      do @(posedge clk); while (!m_tvalid);
      got = {m_tdata[15:0], m_tdata[27:16], m_tuser, m_tlast};
      rows_seen++;
      msg = sb.check_row(got);
      if (msg != "") report(msg);
    end
  end

  initial begin
    sb = new();
    errors = 0;
    items_sent = 0;
    rows_seen = 0;
    columns_run = 0;
    cycles = 0;
    send_gaps = 1;
    recv_gaps = 1;
    hold_request = 0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = cfc_pkg::CMD_SAMPLE;
    s_tlast = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_addr = cfc_pkg::CFG_BEGIN;
    cfg_wdata = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: reset settings, then extremes of support, step and padding
    configure(5'd0, 5'd0, 4'd1, 1'b1);
    load_coefs(3000);
    send(cfc_pkg::CMD_COEF, 5'd31, 18'h1ffff, 16'hffff, 1'b0);
    send(cfc_pkg::CMD_SAMPLE, 5'd0, 18'h0, 16'hffff, 1'b1);
    // every sample gives a row here, so a long receiver stall backs up the input
    send_gaps = 0;
    hold_request = 1;
    run_column(8);
    send_gaps = 1;
    configure(5'b10001, 5'b01111, 4'd1, 1'b1);
    run_column(3);
    configure(5'b10001, 5'b01111, 4'd8, 1'b0);
    run_column(2);
    configure(5'b01111, 5'b10001, 4'd0, 1'b0);   // begin acts as 0, end below begin
    run_column(3);
    configure(5'b11101, 5'd2, 4'd15, 1'b1);
    run_column(5);

    // random settings and columns
    for (int ph = 0; ph < 8; ph++) begin
      configure(-$urandom_range(0, 15), $urandom_range(0, 31), $urandom_range(0, 15),
                $urandom_range(0, 1));
      if (ph % 4 == 0) load_coefs(ph == 4 ? 0 : 6000);
      for (int c = 0; c < 3; c++) begin
        send_gaps = $urandom_range(0, 2) != 0;
        recv_gaps = $urandom_range(0, 2) != 0;
        if (ph == 4 && c == 1) begin
          // receiver stalls long while the sender streams back to back
          send_gaps = 0;
          hold_request = 1;
        end
        run_column($urandom_range(1, 8));
        if (ph == 6 && c == 0) begin
          @(negedge clk);
          s_tvalid = 1'b0;
          while (sb.pending() != 0) @(negedge clk);
        end
      end
    end

    drain();
    $display("covered %0d input transactions over %0d columns, %0d rows checked",
             items_sent, columns_run, rows_seen);
    $display("supports from single tap to full window, both padding modes, long output stalls");
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/cfc_pkg.sv
hw/rtl/cfc_cell.sv
hw/rtl/cfc_div.sv
hw/rtl/cfc_mac.sv
hw/rtl/column_fir_with_edge_padding_top.sv
dv/testbench.sv
